// ===== src/srks_pkg.sv =====
// ----------------------------------------------------------------------------
// srks_pkg: shared types and constants of the sorted record key scanner.
// Holds the item formats, the parse phases, the comparison codes and the
// sizes of the target key store.
// ----------------------------------------------------------------------------
package srks_pkg;

  // Longest target key that is kept; later key bytes are dropped.
  localparam int MAX_KEY_LEN = 64;
  localparam int KEY_AW      = $clog2(MAX_KEY_LEN);
  localparam int TLEN_W      = $clog2(MAX_KEY_LEN + 1);

  // Configuration port: byte address width and register indexes.
  localparam int CFG_AW = 3;
  localparam logic REG_TOMBSTONE = 1'b0;
  localparam logic [7:0] TOMBSTONE_RST = 8'd1;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KEY   = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOTFOUND  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  // Position within a record.
  typedef enum logic [2:0] {
    PH_KLEN  = 3'd0,
    PH_KEY   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_VLEN  = 3'd3,
    PH_VALUE = 3'd4,
    PH_SKIP  = 3'd5
  } phase_e;

  // Outcome of the key comparison so far.
  typedef enum logic [1:0] {
    CMP_EQ  = 2'd0,
    CMP_LT  = 2'd1,
    CMP_GT  = 2'd2,
    CMP_DEL = 2'd3
  } cmp_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       final_result;
  } out_item_t;

  // Write port of the target key store.
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [7:0]        data;
  } key_wr_t;

endpackage

// ===== src/srks_key_mem.sv =====
// ----------------------------------------------------------------------------
// srks_key_mem: target key store.
// One write port and one read port with registered read data; a write to the
// address being read is passed straight to the read register.
// ----------------------------------------------------------------------------
module srks_key_mem
  import srks_pkg::*;
(
  input  logic              clk,
  input  key_wr_t           wr,
  input  logic [KEY_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MAX_KEY_LEN];
  logic [7:0] rd_data_r;

  // Key byte write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read, new data first when both ports meet.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/srks_parser.sv =====
// ----------------------------------------------------------------------------
// srks_parser: record parser and key comparator.
// Takes one item per enabled cycle, updates the parse state and produces at
// most one result. The target byte for the current key position is read
// from the key store ahead of its use, through the registered read port.
// ----------------------------------------------------------------------------
module srks_parser
  import srks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  in_item_t          item,
  input  logic [7:0]        tombstone,
  input  logic [7:0]        key_rd_data,
  output key_wr_t           key_wr,
  output logic [KEY_AW-1:0] key_rd_addr,
  output logic              res_vld,
  output out_item_t         res,
  output logic              search_done
);

  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  phase_e            phase_r, phase_nxt;
  logic [1:0]        fbc_r, fbc_nxt;
  logic [31:0]       rkl_r, rkl_nxt;
  logic [31:0]       rvl_r, rvl_nxt;
  logic [31:0]       bc_r, bc_nxt;
  cmp_e              cmp_r, cmp_nxt;
  logic              done_r, done_nxt;
  logic              started_r, started_nxt;

  logic        data_op;
  logic [31:0] byte_ins;
  logic [31:0] rkl_full;
  logic [31:0] rvl_full;
  logic [31:0] bc_inc;
  logic [31:0] tlen_ext;
  logic        tgt_hit;
  cmp_e        cmp_key;

  // Shared terms.
  assign data_op  = en && (item.operation == OP_DATA) && !done_r;
  assign byte_ins = {24'h0, item.data_byte} << {fbc_r, 3'b000};
  assign rkl_full = rkl_r | byte_ins;
  assign rvl_full = rvl_r | byte_ins;
  assign bc_inc   = bc_r + 32'd1;
  assign tlen_ext = {{(32-TLEN_W){1'b0}}, tlen_r};
  assign tgt_hit  = (bc_r < tlen_ext) && (bc_r < 32'(MAX_KEY_LEN));

  // Comparison of one record key byte with the stored target byte.
  always_comb begin
    cmp_key = cmp_r;
    if (cmp_r == CMP_EQ) begin
      if (tgt_hit) begin
        if (item.data_byte < key_rd_data) begin
          cmp_key = CMP_LT;
        end else if (item.data_byte > key_rd_data) begin
          cmp_key = CMP_GT;
        end
      end else begin
        cmp_key = CMP_GT;
      end
    end
  end

  // Next state.
  always_comb begin
    tlen_nxt    = tlen_r;
    phase_nxt   = phase_r;
    fbc_nxt     = fbc_r;
    rkl_nxt     = rkl_r;
    rvl_nxt     = rvl_r;
    bc_nxt      = bc_r;
    cmp_nxt     = cmp_r;
    started_nxt = started_r;
    key_wr      = '0;
    if (en) begin
      unique case (item.operation)
        OP_START: begin
          tlen_nxt    = '0;
          phase_nxt   = PH_KLEN;
          fbc_nxt     = '0;
          rkl_nxt     = '0;
          rvl_nxt     = '0;
          bc_nxt      = '0;
          cmp_nxt     = CMP_EQ;
          started_nxt = 1'b0;
        end
        OP_KEY: begin
          if (!done_r && !started_r && (tlen_r < TLEN_W'(MAX_KEY_LEN))) begin
            key_wr.en   = 1'b1;
            key_wr.addr = tlen_r[KEY_AW-1:0];
            key_wr.data = item.data_byte;
            tlen_nxt    = tlen_r + TLEN_W'(1);
          end
        end
        OP_DATA: begin
          if (!done_r) begin
            started_nxt = 1'b1;
            unique case (phase_r)
              PH_KLEN: begin
                rkl_nxt = rkl_full;
                if (fbc_r != 2'd3) begin
                  fbc_nxt = fbc_r + 2'd1;
                end else begin
                  fbc_nxt = '0;
                  bc_nxt  = '0;
                  if (rkl_full == 32'd0) begin
                    if (tlen_r != '0) begin
                      cmp_nxt = CMP_LT;
                    end
                    phase_nxt = PH_TYPE;
                  end else begin
                    phase_nxt = PH_KEY;
                  end
                end
              end
              PH_KEY: begin
                cmp_nxt = cmp_key;
                bc_nxt  = bc_inc;
                if (bc_inc == rkl_r) begin
                  if ((cmp_key == CMP_EQ) && (rkl_r < tlen_ext)) begin
                    cmp_nxt = CMP_LT;
                  end
                  phase_nxt = PH_TYPE;
                end
              end
              PH_TYPE: begin
                if ((cmp_r == CMP_EQ) && (item.data_byte == tombstone)) begin
                  cmp_nxt = CMP_DEL;
                end
                phase_nxt = PH_VLEN;
                fbc_nxt   = '0;
              end
              PH_VLEN: begin
                rvl_nxt = rvl_full;
                if (fbc_r != 2'd3) begin
                  fbc_nxt = fbc_r + 2'd1;
                end else begin
                  fbc_nxt = '0;
                  bc_nxt  = '0;
                  // A deleted or greater key ends the search through done.
                  if (cmp_r == CMP_EQ) begin
                    phase_nxt = PH_VALUE;
                  end else if (cmp_r == CMP_LT) begin
                    if (rvl_full == 32'd0) begin
                      phase_nxt = PH_KLEN;
                      rkl_nxt   = '0;
                      rvl_nxt   = '0;
                      cmp_nxt   = CMP_EQ;
                    end else begin
                      phase_nxt = PH_SKIP;
                    end
                  end
                end
              end
              PH_VALUE: begin
                bc_nxt = bc_inc;
              end
              PH_SKIP: begin
                bc_nxt = bc_inc;
                if (bc_inc == rvl_r) begin
                  phase_nxt = PH_KLEN;
                  fbc_nxt   = '0;
                  rkl_nxt   = '0;
                  rvl_nxt   = '0;
                  bc_nxt    = '0;
                  cmp_nxt   = CMP_EQ;
                end
              end
              default: begin
                phase_nxt = PH_KLEN;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the current item.
  always_comb begin
    res_vld          = 1'b0;
    res.status       = ST_MALFORMED;
    res.value_byte   = 8'h00;
    res.has_byte     = 1'b0;
    res.final_result = 1'b1;
    if (data_op) begin
      unique case (phase_r) inside
        PH_KLEN, PH_KEY, PH_TYPE: begin
          res_vld = item.block_end;
        end
        PH_VLEN: begin
          if (fbc_r != 2'd3) begin
            res_vld = item.block_end;
          end else if (cmp_r == CMP_DEL) begin
            res_vld    = 1'b1;
            res.status = ST_DELETED;
          end else if (cmp_r == CMP_GT) begin
            res_vld    = 1'b1;
            res.status = ST_NOTFOUND;
          end else if (cmp_r == CMP_EQ) begin
            if (rvl_full == 32'd0) begin
              res_vld    = 1'b1;
              res.status = ST_FOUND;
            end else begin
              res_vld = item.block_end;
            end
          end else begin
            // Smaller key: an empty value closes the record here.
            res_vld = item.block_end;
            if (rvl_full == 32'd0) begin
              res.status = ST_NOTFOUND;
            end
          end
        end
        PH_VALUE: begin
          res_vld = 1'b1;
          if (bc_inc == rvl_r) begin
            res.status     = ST_FOUND;
            res.value_byte = item.data_byte;
            res.has_byte   = 1'b1;
          end else if (!item.block_end) begin
            res.status       = ST_FOUND;
            res.value_byte   = item.data_byte;
            res.has_byte     = 1'b1;
            res.final_result = 1'b0;
          end
        end
        PH_SKIP: begin
          res_vld = item.block_end;
          if (bc_inc == rvl_r) begin
            res.status = ST_NOTFOUND;
          end
        end
        default: begin
          res_vld = item.block_end;
        end
      endcase
    end
  end

  // A final result closes the search; a start opens a new one.
  always_comb begin
    done_nxt = done_r;
    if (en && (item.operation == OP_START)) begin
      done_nxt = 1'b0;
    end else if (res_vld && res.final_result) begin
      done_nxt = 1'b1;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r    <= '0;
      phase_r   <= PH_KLEN;
      fbc_r     <= '0;
      rkl_r     <= '0;
      rvl_r     <= '0;
      bc_r      <= '0;
      cmp_r     <= CMP_EQ;
      done_r    <= 1'b1;
      started_r <= 1'b0;
    end else begin
      tlen_r    <= tlen_nxt;
      phase_r   <= phase_nxt;
      fbc_r     <= fbc_nxt;
      rkl_r     <= rkl_nxt;
      rvl_r     <= rvl_nxt;
      bc_r      <= bc_nxt;
      cmp_r     <= cmp_nxt;
      done_r    <= done_nxt;
      started_r <= started_nxt;
    end
  end

  // The read port follows the key position of the next cycle.
  assign key_rd_addr = bc_nxt[KEY_AW-1:0];
  assign search_done = done_r;

endmodule

// ===== src/sorted_record_key_scanner.sv =====
// ----------------------------------------------------------------------------
// sorted_record_key_scanner: looks up one target key in a sorted data block.
// A search starts with a start item, takes the target key bytes and then the
// block bytes, and answers found (with the value bytes), deleted, not found
// or malformed.
//
//   Port group   Direction  Handshake            Payload
//   in_*         in         in_valid / in_stall  in_item (in_item_t)
//   out_*        out        out_valid/out_stall  out_item (out_item_t)
//   APB          in/out     psel, penable        paddr, pwdata, prdata
//
// One item is taken per cycle, sustained while the output is not stalled.
// An item passes an input register and the parser, and its result is then
// held in the output register; the key store is read ahead of its use, so
// it adds nothing on that path.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds its item and stalls the input register behind it.
// ----------------------------------------------------------------------------
module sorted_record_key_scanner
  import srks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic              in_vld_r;
  in_item_t          in_r;
  logic              out_vld_r;
  out_item_t         out_r;
  logic [7:0]        tomb_r;
  logic              adv;
  logic              proc_en;
  key_wr_t           key_wr;
  logic [KEY_AW-1:0] key_rd_addr;
  logic [7:0]        key_rd_data;
  logic              res_vld;
  out_item_t         res;
  logic              search_done;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tomb_r <= TOMBSTONE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOMBSTONE)) begin
      tomb_r <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == REG_TOMBSTONE) ? {24'h0, tomb_r} : 32'h0;

  // Handshake: the stage advances whenever the output register can take.
  assign adv      = !out_vld_r || !out_stall;
  assign proc_en  = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_item;
    end
  end

  srks_key_mem u_key_mem (
    .clk     (clk),
    .wr      (key_wr),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  srks_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (proc_en),
    .item        (in_r),
    .tombstone   (tomb_r),
    .key_rd_data (key_rd_data),
    .key_wr      (key_wr),
    .key_rd_addr (key_rd_addr),
    .res_vld     (res_vld),
    .res         (res),
    .search_done (search_done)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // A held input item stays put while the output is blocked.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_r)))
    else $error("input register changed while blocked");

  // A value byte is only ever carried by a found result.
  a_byte_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.has_byte) |-> (out_r.status == ST_FOUND))
    else $error("value byte on a result that is not found");

  // A final result closes the search.
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.final_result) |=> search_done)
    else $error("search still open after its final result");

  // No result appears without an item being worked on.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> proc_en)
    else $error("result without an item in the stage");

endmodule
